/* rtl/core/dsdw_pkg.sv */
// shared types, constants and the segment pattern table of the decimal segment display writer
package dsdw_pkg;

    localparam int unsigned DIGIT_COUNT = 6;
    localparam int unsigned ROW_COUNT   = 4;
    localparam int unsigned ROW_BYTES   = 3;
    localparam int unsigned MEM_BYTES   = ROW_COUNT * ROW_BYTES;
    localparam int unsigned VALUE_W     = 20;
    localparam int unsigned IN_DATA_W   = 24;
    localparam int unsigned OUT_DATA_W  = MEM_BYTES * 8;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned PATTERN_W   = 16;

    // floor(v / 10) == (v * RECIP10) >> RECIP10_SHIFT for every 20-bit v
    localparam logic [VALUE_W-1:0] RECIP10       = 20'hCCCCD;
    localparam int unsigned        RECIP10_SHIFT = 23;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_DIGIT,
        ST_SEND
    } t_state;

    // one nibble write request into the segment store
    typedef struct packed {
        logic               en;
        logic [POS_W-1:0]   pos;
        logic [DIGIT_W-1:0] digit;
    } t_seg_wr;

    // one nibble per common row, row 0 in the low nibble
    function automatic logic [PATTERN_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [PATTERN_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 16'h1551;
            4'd1:    pat = 16'h2080;
            4'd2:    pat = 16'h1E11;
            4'd3:    pat = 16'h1B11;
            4'd4:    pat = 16'h0B50;
            4'd5:    pat = 16'h1B41;
            4'd6:    pat = 16'h1F41;
            4'd7:    pat = 16'h0111;
            4'd8:    pat = 16'h1F51;
            4'd9:    pat = 16'h0B51;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

/* rtl/core/dsdw_div10.sv */
// divide-by-ten unit by reciprocal multiplication, shared by every digit step
module dsdw_div10 (
    input  logic [dsdw_pkg::VALUE_W-1:0] i_value,
    output logic [dsdw_pkg::VALUE_W-1:0] o_quot
);

    localparam int unsigned PROD_W = 2 * dsdw_pkg::VALUE_W;

    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(i_value) * PROD_W'(dsdw_pkg::RECIP10);
    assign o_quot = dsdw_pkg::VALUE_W'(w_prod >> dsdw_pkg::RECIP10_SHIFT);

endmodule

/* rtl/core/dsdw_seg_store.sv */
// segment memory: four rows of three bytes, one position's nibble in every row replaced per write
module dsdw_seg_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dsdw_pkg::t_seg_wr                   i_wr,
    output logic [dsdw_pkg::OUT_DATA_W-1:0]     o_bytes
);

    logic [dsdw_pkg::PATTERN_W-1:0] w_pat;
    logic [15:0]                    w_pat16;

    assign w_pat   = dsdw_pkg::seg_pattern(i_wr.digit);
    assign w_pat16 = 16'(w_pat);

    for (genvar r = 0; r < dsdw_pkg::ROW_COUNT; r++) begin : g_row
        for (genvar c = 0; c < dsdw_pkg::ROW_BYTES; c++) begin : g_byte
            logic [7:0] r_byte;
            logic       w_hit;

            assign w_hit = i_wr.en && (i_wr.pos[2:1] == 2'(c));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_byte <= '0;
                end else if (w_hit) begin
                    if (i_wr.pos[0]) begin
                        r_byte[7:4] <= w_pat16[4*r +: 4];
                    end else begin
                        r_byte[3:0] <= w_pat16[4*r +: 4];
                    end
                end
            end

            assign o_bytes[8*(r*dsdw_pkg::ROW_BYTES + c) +: 8] = r_byte;
        end
    end

endmodule

/* rtl/core/decimal_segment_display_writer.sv */
// top level: sequencer that writes a number in decimal into the segment memory
//
// Each input beat carries a 20-bit unsigned number. The block peels off decimal
// digits from the ones digit upward, one digit per cycle, and writes each into
// the next position to the left, starting at the rightmost of six positions.
// It stops when the remaining quotient is zero or the positions run out, so
// leading positions keep what they held, a zero value changes nothing, and only
// the low six digits of a larger value are shown. Each digit selects a segment
// pattern of four nibbles; nibble k of it replaces that position's nibble in
// common row k. After every input beat one output beat carries all twelve
// memory bytes.
// Sequence: the input beat is taken in the idle state, ST_PRIME loads the shared
// divide-by-ten multiplier, then ST_DIGIT writes one digit per step (at most six),
// then ST_SEND offers the output beat and holds it until the sink raises tready;
// a zero value goes from ST_PRIME straight to ST_SEND.
// Only one item is in flight; s_axis_tready is high only while idle. A synchronous
// reset blanks the display memory.
module decimal_segment_display_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] number_value, [23:20] zero
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // row0_byte0 .. row0_byte2, row1_byte0 .. row3_byte2,
                                        // eight bits each from bit 0 up
);

    localparam int unsigned VW = dsdw_pkg::VALUE_W;
    localparam int unsigned PW = dsdw_pkg::POS_W;

    dsdw_pkg::t_state r_state, n_state;

    // value still to be converted and its quotient by ten
    logic [VW-1:0] r_val, n_val;
    logic [VW-1:0] r_q,   n_q;
    // positions left; the next digit goes to r_pos - 1
    logic [PW-1:0] r_pos, n_pos;

    logic [VW-1:0]     w_div_in;
    logic [VW-1:0]     w_div_q;
    logic [VW-1:0]     w_rem;
    dsdw_pkg::t_seg_wr w_wr;

    // shared divider: the loaded value when priming, the running quotient after
    assign w_div_in = (r_state == dsdw_pkg::ST_PRIME) ? r_val : r_q;

    dsdw_div10 u_div10 (
        .i_value (w_div_in),
        .o_quot  (w_div_q)
    );

    // remainder = value - 10 * quotient, below ten in ST_DIGIT where it is written
    assign w_rem = r_val - ((r_q << 3) + (r_q << 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsdw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_q   <= n_q;
        r_pos <= n_pos;
    end

    always_comb begin
        n_state       = r_state;
        n_val         = r_val;
        n_q           = r_q;
        n_pos         = r_pos;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_wr.en       = 1'b0;
        w_wr.pos      = r_pos - PW'(1);
        w_wr.digit    = w_rem[dsdw_pkg::DIGIT_W-1:0];
        unique case (r_state)
            dsdw_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_val   = s_axis_tdata[VW-1:0];
                    n_pos   = PW'(dsdw_pkg::DIGIT_COUNT);
                    n_state = dsdw_pkg::ST_PRIME;
                end
            end
            dsdw_pkg::ST_PRIME: begin
                n_q = w_div_q;
                // zero value writes nothing
                n_state = (r_val == '0) ? dsdw_pkg::ST_SEND : dsdw_pkg::ST_DIGIT;
            end
            dsdw_pkg::ST_DIGIT: begin
                w_wr.en = 1'b1;
                n_val   = r_q;
                n_q     = w_div_q;
                n_pos   = r_pos - PW'(1);
                // stop at a zero quotient or at the leftmost position
                if (r_q == '0 || r_pos == PW'(1)) begin
                    n_state = dsdw_pkg::ST_SEND;
                end
            end
            dsdw_pkg::ST_SEND: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = dsdw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dsdw_pkg::ST_IDLE;
            end
        endcase
    end

    // memory is only written in ST_DIGIT, so the output beat stays stable
    dsdw_seg_store u_seg_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_bytes (m_axis_tdata)
    );

endmodule
